[rtl/collation_order_sorted_check_assert.svh]
// Assertion macros for the collation order checker.
`ifndef COLLATION_ORDER_SORTED_CHECK_ASSERT_SVH
`define COLLATION_ORDER_SORTED_CHECK_ASSERT_SVH

// Plain property, checked outside reset.
`define COSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next, outside reset.
`define COSC_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/cosc_pkg.sv]
// Package: constants, status codes and rank lookup for the collation order checker.
`timescale 1ns / 1ps

package cosc_pkg;

  // Word buffer geometry
  localparam int MAX_WORD_LEN = 32;
  localparam int IDX_W        = $clog2(MAX_WORD_LEN);
  localparam int POS_W        = 6;

  // Alphabet and rank layout
  localparam int LETTERS   = 26;
  localparam int CODE_W    = 5;
  localparam int RANK_W    = 6;
  localparam int TABLE_W   = LETTERS * CODE_W;
  localparam int RANK_LO_W = 60;
  localparam int RANK_HI_W = 10;

  localparam logic [RANK_LO_W-1:0] RANK_LOW_RESET  = 60'd407901468851537952;
  localparam logic [RANK_LO_W-1:0] RANK_MID_RESET  = 60'd854193664183220652;
  localparam logic [RANK_HI_W-1:0] RANK_HIGH_RESET = 10'd824;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_HIGH = 2'd2;

  // Comparison status of the current word against the previous one
  localparam logic [1:0] ST_EQUAL = 2'd0;  // equal so far
  localparam logic [1:0] ST_BELOW = 2'd1;  // current word sorts after previous
  localparam logic [1:0] ST_ABOVE = 2'd2;  // previous word sorts after current

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [RANK_W-1:0] rank_t;

  // Rank of a letter code; codes past the alphabet rank above every table entry
  function automatic rank_t rank_of(input code_t code, input logic [TABLE_W-1:0] tbl);
    logic [6:0] base;
    base = 7'(code) * 7'd5;
    if (code < CODE_W'(LETTERS)) begin
      rank_of = {1'b0, tbl[base +: CODE_W]};
    end else begin
      rank_of = RANK_W'(code) + RANK_W'(6);
    end
  endfunction

endpackage

[rtl/collation_order_sorted_check.sv]
// Top level: streaming checker for lexicographic order under a configurable collation.
//
//  channel | direction | tdata / data                 | sideband
//  --------+-----------+------------------------------+-------------------------------
//  in_     | slave     | [4:0] letter                 | tuser word_end, tlast list_end
//  out_    | master    | [0] in_order, [1] too_long   | -
//  cfg_    | slave     | cfg_data rank value          | cfg_index register number
//
//  One letter is taken per cycle; the previous-word compare, rank lookup and
//  buffer write all happen in the cycle of the transfer.
//  The verdict appears in the output register in the cycle after the list_end transfer.
//  Input stalls only while a verdict waits in the output register and out_tready is low.
//  Reset (synchronous, rst_n low) restores the identity collation and clears list state;
//  the word buffer is not cleared, as only entries of the previous word are ever read.
//  Configuration writes are taken every cycle (cfg_ready is tied high).
`timescale 1ns / 1ps

module collation_order_sorted_check
  import cosc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input letters
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [4:0] letter, [7:5] zero
  input  logic                 in_tuser,   // [0] word_end
  input  logic                 in_tlast,   // list_end
  // verdicts
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] in_order, [1] too_long, [7:2] zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RANK_LO_W-1:0] cfg_data
);

`include "collation_order_sorted_check_assert.svh"

  // Rank tables
  logic [RANK_LO_W-1:0] rank_low_r;
  logic [RANK_LO_W-1:0] rank_mid_r;
  logic [RANK_HI_W-1:0] rank_high_r;
  logic [TABLE_W-1:0]   rank_tbl;

  // List state
  code_t            prev_word_r [MAX_WORD_LEN];
  logic [POS_W-1:0] prev_len_r, prev_len_nxt;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             sorted_r, sorted_nxt;
  logic             overflow_r, overflow_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_data_r;

  // Per-transfer working signals
  logic             in_xfer;
  code_t            letter;
  code_t            old_letter;
  logic             pos_ok;
  logic             word_done;
  logic [1:0]       status_upd;
  logic [POS_W-1:0] pos_after;
  logic             overflow_after;
  logic             sorted_after;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

  assign rank_tbl   = {rank_high_r, rank_mid_r, rank_low_r};
  assign letter     = in_tdata[CODE_W-1:0];
  assign word_done  = in_tuser || in_tlast;
  assign pos_ok     = position_r < POS_W'(MAX_WORD_LEN);
  assign old_letter = prev_word_r[position_r[IDX_W-1:0]];

  // Compare this letter against the previous word at the same place
  always_comb begin
    status_upd = status_r;
    if (pos_ok && (prev_len_r != '0) && (status_r == ST_EQUAL)) begin
      if (position_r < prev_len_r) begin
        if (old_letter != letter) begin
          status_upd = (rank_of(old_letter, rank_tbl) > rank_of(letter, rank_tbl)) ?
                       ST_ABOVE : ST_BELOW;
        end
      end else begin
        // previous word is a proper prefix of this one
        status_upd = ST_BELOW;
      end
    end
  end

  assign pos_after      = pos_ok ? position_r + POS_W'(1) : position_r;
  assign overflow_after = overflow_r || !pos_ok;

  // Word end: out of order if previous sorts after, or if this word is a shorter prefix
  assign sorted_after = sorted_r &&
                        !(word_done && (prev_len_r != '0) &&
                          ((status_upd == ST_ABOVE) ||
                           ((status_upd == ST_EQUAL) && (pos_after < prev_len_r))));

  // Next list state and output
  always_comb begin
    prev_len_nxt  = prev_len_r;
    position_nxt  = position_r;
    status_nxt    = status_r;
    sorted_nxt    = sorted_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_xfer) begin
      position_nxt = pos_after;
      status_nxt   = status_upd;
      sorted_nxt   = sorted_after;
      overflow_nxt = overflow_after;
      if (word_done) begin
        prev_len_nxt = pos_after;
        position_nxt = '0;
        status_nxt   = ST_EQUAL;
      end
      if (in_tlast) begin
        out_valid_nxt = 1'b1;
        prev_len_nxt  = '0;
        sorted_nxt    = 1'b1;
        overflow_nxt  = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_low_r  <= RANK_LOW_RESET;
      rank_mid_r  <= RANK_MID_RESET;
      rank_high_r <= RANK_HIGH_RESET;
      prev_len_r  <= '0;
      position_r  <= '0;
      status_r    <= ST_EQUAL;
      sorted_r    <= 1'b1;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_len_r  <= prev_len_nxt;
      position_r  <= position_nxt;
      status_r    <= status_nxt;
      sorted_r    <= sorted_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RANK_LOW:  rank_low_r  <= cfg_data;
          CFG_RANK_MID:  rank_mid_r  <= cfg_data;
          CFG_RANK_HIGH: rank_high_r <= cfg_data[RANK_HI_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Word buffer and verdict payload
  always_ff @(posedge clk) begin
    if (in_xfer && pos_ok) begin
      prev_word_r[position_r[IDX_W-1:0]] <= letter;
    end
    if (in_xfer && in_tlast) begin
      out_data_r <= {overflow_after, sorted_after};
    end
  end

  // Checks
  `COSC_ASSERT(a_pos_range, position_r <= POS_W'(MAX_WORD_LEN), "position past buffer")
  `COSC_ASSERT(a_len_range, prev_len_r <= POS_W'(MAX_WORD_LEN), "length past buffer")
  `COSC_ASSERT_NEXT(a_verdict_follows, in_xfer && in_tlast, out_valid_r, "no verdict")
  `COSC_ASSERT_NEXT(a_list_cleared, in_xfer && in_tlast, sorted_r && !overflow_r, "flags kept")
  `COSC_ASSERT_NEXT(a_word_restart, in_xfer && word_done, position_r == '0, "word not restarted")
  `COSC_ASSERT_NEXT(a_status_restart, in_xfer && word_done, status_r == ST_EQUAL, "status kept")

endmodule

[tb/cosc_tb_pkg.sv]
// Verdict scoreboard for the collation order checker: list-state prediction and result compare.
`timescale 1ns / 1ps

package cosc_tb_pkg;
  import cosc_pkg::*;

  typedef struct packed {
    logic too_long;
    logic in_order;
  } verdict_t;

  class collation_verdicts;
    // collation table as programmed
    logic [RANK_LO_W-1:0] low_ranks;
    logic [RANK_LO_W-1:0] mid_ranks;
    logic [RANK_HI_W-1:0] high_ranks;
    // list state
    code_t       stored_word[MAX_WORD_LEN];
    int unsigned stored_len;
    int unsigned cur_pos;
    logic [1:0]  cmp_state;
    bit          pairs_ok;
    bit          overlong;
    verdict_t    expected_verdicts[$];
    // tallies
    int errors;
    int checked;
    int lists;
    int letters;
    int sorted_lists;
    int overlong_lists;

    function new();
      low_ranks  = RANK_LOW_RESET;
      mid_ranks  = RANK_MID_RESET;
      high_ranks = RANK_HIGH_RESET;
      foreach (stored_word[i]) stored_word[i] = '0;
      restart_list();
      errors         = 0;
      checked        = 0;
      lists          = 0;
      letters        = 0;
      sorted_lists   = 0;
      overlong_lists = 0;
    endfunction

    function void restart_list();
      stored_len = 0;
      cur_pos    = 0;
      cmp_state  = ST_EQUAL;
      pairs_ok   = 1'b1;
      overlong   = 1'b0;
    endfunction

    // Codes past the alphabet sit above any 5-bit table rank
    function int unsigned rank(code_t c);
      int unsigned k = c;
      if (k < 12) return low_ranks[5*k +: 5];
      else if (k < 24) return mid_ranks[5*(k-12) +: 5];
      else if (k < LETTERS) return high_ranks[5*(k-24) +: 5];
      else return k + 6;
    endfunction

    // Unmapped indexes leave the table alone
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RANK_LO_W-1:0] val);
      case (idx)
        CFG_RANK_LOW:  low_ranks = val;
        CFG_RANK_MID:  mid_ranks = val;
        CFG_RANK_HIGH: high_ranks = val[RANK_HI_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_letter(code_t letter, bit word_end, bit list_end);
      verdict_t v;
      letters++;
      // compare against the stored word, then overwrite it in place
      if (cur_pos < MAX_WORD_LEN) begin
        if (stored_len > 0 && cmp_state == ST_EQUAL) begin
          if (cur_pos < stored_len) begin
            if (stored_word[cur_pos] != letter)
              cmp_state = (rank(stored_word[cur_pos]) > rank(letter)) ? ST_ABOVE : ST_BELOW;
          end else begin
            cmp_state = ST_BELOW;
          end
        end
        stored_word[cur_pos] = letter;
        cur_pos++;
      end else begin
        overlong = 1'b1;
      end
      // word close: a pending prefix match with a longer stored word is out of order
      if (word_end || list_end) begin
        if (stored_len > 0 &&
            (cmp_state == ST_ABOVE || (cmp_state == ST_EQUAL && cur_pos < stored_len)))
          pairs_ok = 1'b0;
        stored_len = cur_pos;
        cur_pos    = 0;
        cmp_state  = ST_EQUAL;
      end
      if (list_end) begin
        v.in_order = pairs_ok;
        v.too_long = overlong;
        expected_verdicts.push_back(v);
        lists++;
        sorted_lists   += pairs_ok;
        overlong_lists += overlong;
        restart_list();
      end
    endfunction

    function void check_verdict(logic [7:0] data);
      verdict_t want;
      checked++;
      if (expected_verdicts.size() == 0) begin
        $error("verdict %0h arrived with no list outstanding", data);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (data[0] !== want.in_order) begin
          $error("in_order mismatch: expected %0b, got %0b", want.in_order, data[0]);
          errors++;
        end
        if (data[1] !== want.too_long) begin
          $error("too_long mismatch: expected %0b, got %0b", want.too_long, data[1]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// Testbench top: drives word lists through the collation order checker across rank tables.
`timescale 1ns / 1ps

module tb_top;
  import cosc_pkg::*;
  import cosc_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register slot
  localparam int DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [4:0] letter, [7:5] zero
  logic                 in_tuser;   // [0] word_end
  logic                 in_tlast;   // list_end
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [7:0]           out_tdata;  // [0] in_order, [1] too_long, [7:2] zero
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RANK_LO_W-1:0] cfg_data;

  collation_verdicts book;
  bit                idling = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       cycles = 0;
  int unsigned       sent = 0;
  int unsigned       lists_sent = 0;

  collation_order_sorted_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe every transfer on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) book.note_letter(in_tdata[CODE_W-1:0], in_tuser, in_tlast);
      if (out_tvalid && out_tready) book.check_verdict(out_tdata);
      if (cfg_valid && cfg_ready) book.write_reg(cfg_index, cfg_data);
    end
  end

  // Result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic code_t any_letter();
    if ($urandom_range(0, 19) == 0) return code_t'($urandom_range(26, 31));
    return code_t'($urandom_range(0, 25));
  endfunction

  function automatic int unsigned word_len();
    if ($urandom_range(0, 29) == 0) return $urandom_range(30, 40);
    return $urandom_range(1, 6);
  endfunction

  // Lower-case letters are codes 0-25, capitals A-F stand for codes 26-31
  function automatic code_t code_of(byte ch);
    if (ch >= "a") return code_t'(ch - "a");
    return code_t'(ch - "A" + 26);
  endfunction

  function automatic logic [TABLE_W-1:0] reversed_table();
    logic [TABLE_W-1:0] tbl;
    for (int k = 0; k < LETTERS; k++) tbl[5*k +: 5] = 5'(LETTERS - 1 - k);
    return tbl;
  endfunction

  task automatic send_letter(code_t letter, bit word_end, bit list_end);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, letter};
    in_tuser  <= word_end;
    in_tlast  <= list_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Last word may close without word_end, leaving list_end to end it
  task automatic send_word(code_t w[$], bit last_word, bit close_word);
    foreach (w[i])
      send_letter(w[i], (i == w.size() - 1) && (!last_word || close_word),
                  last_word && (i == w.size() - 1));
    if (last_word) lists_sent++;
  endtask

  task automatic send_list(string s, bit close_word);
    bit word_last;
    bit final_char;
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] != " ") begin
        final_char = (i == s.len() - 1);
        word_last  = final_char || (s[i+1] == " ");
        send_letter(code_of(s[i]), word_last && (!final_char || close_word), final_char);
        if (final_char) lists_sent++;
      end
    end
  endtask

  // Hold input until every verdict is back, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (book.checked < lists_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [RANK_LO_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Spare slot is written too; the checker must ignore it
  task automatic load_table(logic [TABLE_W-1:0] tbl);
    drain();
    program_reg(CFG_SPARE, RANK_LO_W'({$urandom, $urandom}));
    program_reg(CFG_RANK_LOW, tbl[RANK_LO_W-1:0]);
    program_reg(CFG_RANK_MID, tbl[2*RANK_LO_W-1:RANK_LO_W]);
    program_reg(CFG_RANK_HIGH, tbl[TABLE_W-1:2*RANK_LO_W]);
    cfg_valid <= 1'b0;
  endtask

  // Lists mostly built from the previous word: shared prefix, then a pivot letter
  task automatic run_lists(int unsigned n_items, bit pause_halfway);
    int unsigned start;
    int unsigned nwords;
    int unsigned p;
    int unsigned tail;
    int unsigned tries;
    bit          noisy;
    bit          keep_order;
    code_t       c;
    code_t       prv[$];
    code_t       cur[$];
    start = sent;
    while (sent - start < n_items) begin
      if (pause_halfway && sent - start >= n_items / 2) begin
        drain();
        pause_halfway = 1'b0;
      end
      noisy      = ($urandom_range(0, 4) == 0);
      keep_order = ($urandom_range(0, 9) < 6);
      nwords     = $urandom_range(1, 6);
      prv.delete();
      for (int w = 0; w < nwords; w++) begin
        cur.delete();
        if (w == 0 || noisy) begin
          repeat (word_len()) cur.push_back(any_letter());
        end else begin
          p = $urandom_range(0, prv.size());
          for (int i = 0; i < p; i++) cur.push_back(prv[i]);
          if (p < prv.size()) begin
            c = any_letter();
            for (tries = 0; keep_order && tries < 8 && book.rank(c) < book.rank(prv[p]);
                 tries++)
              c = any_letter();
            if (keep_order && book.rank(c) < book.rank(prv[p])) c = prv[p];
            if (keep_order || $urandom_range(0, 3) != 0) cur.push_back(c);
          end
          tail = ($urandom_range(0, 29) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 3);
          repeat (tail) cur.push_back(any_letter());
          if (cur.size() == 0) cur.push_back(any_letter());
        end
        send_word(cur, w == nwords - 1, 1'($urandom_range(0, 1)));
        prv = cur;
      end
    end
  endtask

  initial begin
    book = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    in_tlast   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_RANK_LOW;
    cfg_data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed lists under the reset (identity) order
    send_list("ab abc abd", 1'b1);  // prefix then longer words
    send_list("b a", 1'b1);         // descending pair
    send_list("abc ab", 1'b1);      // longer word before its prefix
    send_list("z F", 1'b0);         // top code, list_end closes the word
    send_list("a", 1'b0);           // single word list
    send_list("cc cc", 1'b1);       // repeated word
    send_list("A z", 1'b1);         // out-of-alphabet code above z

    run_lists(200, 1'b1);
    load_table('0);                 // every letter ranks equal
    run_lists(200, 1'b0);
    idling = 1'b0;
    load_table('1);
    run_lists(150, 1'b0);
    idling = 1'b1;
    load_table(reversed_table());
    run_lists(200, 1'b0);
    load_table(TABLE_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    run_lists(250, 1'b0);
    // closing stretch: identity order, no idling
    idling = 1'b0;
    load_table({RANK_HIGH_RESET, RANK_MID_RESET, RANK_LOW_RESET});
    run_lists(200, 1'b0);
    drain();

    $display("Run covered %0d lists, %0d letters, under six rank tables.",
             book.lists, book.letters);
    $display("%0d lists judged in order, %0d with an overlong word.",
             book.sorted_lists, book.overlong_lists);
    if (book.errors == 0 && book.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
